// File: rtl/arpc_pkg.sv
// Shared types, codes and reset constants of the address cache table.
`default_nettype none

package arpc_pkg;

    localparam int ARPC_TABLE_ENTRIES = 16;

    // Configuration port geometry: three registers at byte addresses 0, 4 and 8.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] CFG_EXPIRE_AGE   = 2'd0;
    localparam logic [1:0] CFG_PROBE_WINDOW = 2'd1;
    localparam logic [1:0] CFG_PROBE_AGE    = 2'd2;

    localparam logic [15:0] EXPIRE_AGE_RST   = 16'd300;
    localparam logic [7:0]  PROBE_WINDOW_RST = 8'd5;
    localparam logic [15:0] PROBE_AGE_RST    = 16'd20;

    localparam logic [1:0] REQ_LEARN  = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [2:0] STAT_REFRESHED = 3'd0;
    localparam logic [2:0] STAT_INSERTED  = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_HIT       = 3'd3;
    localparam logic [2:0] STAT_MISS      = 3'd4;
    localparam logic [2:0] STAT_PROBE     = 3'd5;
    localparam logic [2:0] STAT_EXPIRED   = 3'd6;
    localparam logic [2:0] STAT_TICK_DONE = 3'd7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] ip_key;
        logic [47:0] mac_value;
        logic [1:0]  iface_id;
    } arpc_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] ip_out;
        logic [47:0] mac_out;
        logic [1:0]  iface_out;
        logic        last;
    } arpc_out_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [1:0]  iface;
    } arpc_entry_t;

    typedef struct packed {
        logic [15:0] expire_age;
        logic [7:0]  probe_recent_window;
        logic [15:0] probe_age;
    } arpc_cfg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } arpc_state_t;

endpackage

`default_nettype wire

// File: rtl/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/arpc_cfg.sv
// APB-style configuration registers for the aging thresholds.
`default_nettype none

module arpc_cfg
    import arpc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output arpc_cfg_t               cfg
);

    arpc_cfg_t  cfg_reg;
    arpc_cfg_t  cfg_next;
    logic [1:0] reg_index;
    logic       wr_strobe;

    assign reg_index = paddr[PADDR_W-1:2];
    assign wr_strobe = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_strobe) begin
            unique case (reg_index)
                CFG_EXPIRE_AGE:   cfg_next.expire_age          = pwdata[15:0];
                CFG_PROBE_WINDOW: cfg_next.probe_recent_window = pwdata[7:0];
                CFG_PROBE_AGE:    cfg_next.probe_age           = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expire_age          <= EXPIRE_AGE_RST;
            cfg_reg.probe_recent_window <= PROBE_WINDOW_RST;
            cfg_reg.probe_age           <= PROBE_AGE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_index)
            CFG_EXPIRE_AGE:   prdata = {16'd0, cfg_reg.expire_age};
            CFG_PROBE_WINDOW: prdata = {24'd0, cfg_reg.probe_recent_window};
            CFG_PROBE_AGE:    prdata = {16'd0, cfg_reg.probe_age};
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/arp_cache_table_unit.sv
// Address cache: a scan sequencer over entry RAMs, one slot per cycle while not stalled.
// An item is accepted in the idle state, then the slots are read in order, one per cycle,
// and a closing state gives the final beat.
// A learn or lookup that matches ends at the matching slot. A held result register stalls.
// Reset clears the valid bits, the tick counter and the output valid flag, and loads the
// thresholds with 300, 5 and 20. Entry RAMs are not cleared; no clearing pass is needed.
`default_nettype none

module arp_cache_table_unit
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = ARPC_TABLE_ENTRIES
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire arpc_in_t           s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output arpc_out_t               m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    arpc_cfg_t    cfg;
    arpc_state_t  state_reg, state_next;
    arpc_in_t     req_reg, req_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic                     free_found_reg, free_found_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]              now_reg, now_next;
    logic                     m_valid_reg, m_valid_next;
    arpc_out_t                m_data_reg, m_data_next;

    logic         emit;
    arpc_out_t    out_beat;
    logic         can_emit;
    logic         stall;
    logic         done_early;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             data_we, learn_we, use_we;
    arpc_entry_t      data_wr, data_rd;
    logic [31:0]      learn_rd, use_rd;

    logic        cur_valid;
    logic        match;
    logic [31:0] used_age, learned_age;
    logic        probe_hit, expire_hit;

    arpc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    arpc_ram #(.WIDTH($bits(arpc_entry_t)), .DEPTH(TABLE_ENTRIES)) u_data_ram (
        .aclk    (aclk),
        .wr_en   (data_we),
        .wr_addr (wr_addr),
        .wr_data (data_wr),
        .rd_addr (rd_addr),
        .rd_data (data_rd)
    );

    arpc_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_learn_ram (
        .aclk    (aclk),
        .wr_en   (learn_we),
        .wr_addr (wr_addr),
        .wr_data (now_reg),
        .rd_addr (rd_addr),
        .rd_data (learn_rd)
    );

    arpc_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_use_ram (
        .aclk    (aclk),
        .wr_en   (use_we),
        .wr_addr (wr_addr),
        .wr_data (now_reg),
        .rd_addr (rd_addr),
        .rd_data (use_rd)
    );

    // Slot evaluation on the data read for idx_reg; ages wrap modulo 2^32.
    assign cur_valid   = valid_reg[idx_reg];
    assign match       = cur_valid && (data_rd.ip == req_reg.ip_key);
    assign used_age    = now_reg - use_rd;
    assign learned_age = now_reg - learn_rd;
    assign probe_hit   = cur_valid && (used_age < {24'd0, cfg.probe_recent_window})
                         && (learned_age > {16'd0, cfg.probe_age});
    assign expire_hit  = cur_valid && !probe_hit && (learned_age > {16'd0, cfg.expire_age});

    assign can_emit = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        valid_next      = valid_reg;
        now_next        = now_reg;
        emit            = 1'b0;
        out_beat        = '0;
        stall           = 1'b0;
        done_early      = 1'b0;
        s_ready         = 1'b0;
        rd_addr         = '0;
        wr_addr         = idx_reg;
        data_we         = 1'b0;
        learn_we        = 1'b0;
        use_we          = 1'b0;
        data_wr.ip      = req_reg.ip_key;
        data_wr.mac     = req_reg.mac_value;
        data_wr.iface   = req_reg.iface_id;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next        = s_data;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    if (s_data.req_type == REQ_TICK) begin
                        now_next = now_reg + 32'd1;
                    end
                    if (s_data.req_type != REQ_NONE) begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (req_reg.req_type == REQ_TICK) begin
                    if (probe_hit || expire_hit) begin
                        if (can_emit) begin
                            emit               = 1'b1;
                            out_beat.status    = probe_hit ? STAT_PROBE : STAT_EXPIRED;
                            out_beat.ip_out    = data_rd.ip;
                            out_beat.mac_out   = data_rd.mac;
                            out_beat.iface_out = data_rd.iface;
                            out_beat.last      = 1'b0;
                            if (expire_hit) begin
                                valid_next[idx_reg] = 1'b0;
                            end
                        end else begin
                            stall = 1'b1;
                        end
                    end
                end else if (match) begin
                    if (can_emit) begin
                        emit               = 1'b1;
                        done_early         = 1'b1;
                        state_next         = S_IDLE;
                        out_beat.ip_out    = data_rd.ip;
                        out_beat.mac_out   = data_rd.mac;
                        out_beat.iface_out = data_rd.iface;
                        out_beat.last      = 1'b1;
                        if (req_reg.req_type == REQ_LEARN) begin
                            out_beat.status = STAT_REFRESHED;
                            learn_we        = 1'b1;
                        end else begin
                            out_beat.status = STAT_HIT;
                            use_we          = 1'b1;
                        end
                    end else begin
                        stall = 1'b1;
                    end
                end else if (!cur_valid && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end

                if (!stall && !done_early) begin
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_FINISH;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                // A stalled slot is read again so its data stays on the RAM output.
                rd_addr = stall ? idx_reg : idx_reg + IDX_W'(1);
            end

            S_FINISH: begin
                if (can_emit) begin
                    emit          = 1'b1;
                    state_next    = S_IDLE;
                    out_beat.last = 1'b1;
                    unique case (req_reg.req_type)
                        REQ_LEARN: begin
                            out_beat.ip_out    = req_reg.ip_key;
                            out_beat.mac_out   = req_reg.mac_value;
                            out_beat.iface_out = req_reg.iface_id;
                            if (free_found_reg) begin
                                out_beat.status          = STAT_INSERTED;
                                wr_addr                  = free_idx_reg;
                                data_we                  = 1'b1;
                                learn_we                 = 1'b1;
                                use_we                   = 1'b1;
                                valid_next[free_idx_reg] = 1'b1;
                            end else begin
                                out_beat.status = STAT_FULL;
                            end
                        end
                        REQ_LOOKUP: begin
                            out_beat.status = STAT_MISS;
                            out_beat.ip_out = req_reg.ip_key;
                        end
                        REQ_TICK: begin
                            out_beat.status = STAT_TICK_DONE;
                        end
                        default: begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = out_beat;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            m_data_next  = m_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            now_reg        <= '0;
            m_valid_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            idx_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            now_reg        <= now_next;
            m_valid_reg    <= m_valid_next;
            free_found_reg <= free_found_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        free_idx_reg <= free_idx_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // An accepted tick advances the counter by exactly one.
    a_tick_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.req_type == REQ_TICK)
        |=> (now_reg == $past(now_reg) + 32'd1))
        else $error("tick counter did not advance on an accepted tick");

    // Results come only from the scan and the closing cycle.
    a_no_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !emit)
        else $error("result produced while idle");

    // An insert lands in a free slot and makes it valid.
    a_insert_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && out_beat.status == STAT_INSERTED)
        |-> !valid_reg[free_idx_reg] ##1 valid_reg[$past(free_idx_reg)])
        else $error("insert did not claim a free slot");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the address cache table: directed and random requests vs a shadow cache.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import arpc_pkg::*;

    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    // Shadow copy of the cache; it computes the reply beats each request owes.
    class arp_cache_shadow;
        bit          slot_live[ARPC_TABLE_ENTRIES];
        logic [31:0] slot_ip[ARPC_TABLE_ENTRIES];
        logic [47:0] slot_mac[ARPC_TABLE_ENTRIES];
        logic [1:0]  slot_iface[ARPC_TABLE_ENTRIES];
        logic [31:0] slot_learned[ARPC_TABLE_ENTRIES];
        logic [31:0] slot_touched[ARPC_TABLE_ENTRIES];
        logic [31:0] tick_count;
        logic [15:0] age_limit;
        logic [7:0]  busy_window;
        logic [15:0] probe_after;
        arpc_out_t   replies_due[$];
        int          mismatches;

        function new();
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            tick_count  = '0;
            age_limit   = EXPIRE_AGE_RST;
            busy_window = PROBE_WINDOW_RST;
            probe_after = PROBE_AGE_RST;
            mismatches  = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] word);
            case (idx)
                CFG_EXPIRE_AGE:   age_limit   = word[15:0];
                CFG_PROBE_WINDOW: busy_window = word[7:0];
                CFG_PROBE_AGE:    probe_after = word[15:0];
                default: ;
            endcase
        endfunction

        function int find_slot(logic [31:0] ip);
            for (int i = 0; i < ARPC_TABLE_ENTRIES; i++)
                if (slot_live[i] && slot_ip[i] == ip)
                    return i;
            return -1;
        endfunction

        function void owe(logic [2:0] status, logic [31:0] ip, logic [47:0] mac,
                          logic [1:0] iface, logic last);
            arpc_out_t r;
            r.status    = status;
            r.ip_out    = ip;
            r.mac_out   = mac;
            r.iface_out = iface;
            r.last      = last;
            replies_due.push_back(r);
        endfunction

        function void owe_slot(logic [2:0] status, int i, logic last);
            owe(status, slot_ip[i], slot_mac[i], slot_iface[i], last);
        endfunction

        function void absorb_request(arpc_in_t rq);
            int          hit;
            int          free;
            logic [31:0] since_use;
            logic [31:0] since_learn;
            case (rq.req_type)
                REQ_LEARN: begin
                    hit = find_slot(rq.ip_key);
                    if (hit >= 0) begin
                        slot_learned[hit] = tick_count;
                        owe_slot(STAT_REFRESHED, hit, 1'b1);
                    end else begin
                        free = -1;
                        for (int i = ARPC_TABLE_ENTRIES - 1; i >= 0; i--)
                            if (!slot_live[i])
                                free = i;
                        if (free < 0) begin
                            owe(STAT_FULL, rq.ip_key, rq.mac_value, rq.iface_id, 1'b1);
                        end else begin
                            slot_live[free]    = 1'b1;
                            slot_ip[free]      = rq.ip_key;
                            slot_mac[free]     = rq.mac_value;
                            slot_iface[free]   = rq.iface_id;
                            slot_learned[free] = tick_count;
                            slot_touched[free] = tick_count;
                            owe_slot(STAT_INSERTED, free, 1'b1);
                        end
                    end
                end
                REQ_LOOKUP: begin
                    hit = find_slot(rq.ip_key);
                    if (hit >= 0) begin
                        slot_touched[hit] = tick_count;
                        owe_slot(STAT_HIT, hit, 1'b1);
                    end else begin
                        owe(STAT_MISS, rq.ip_key, '0, '0, 1'b1);
                    end
                end
                REQ_TICK: begin
                    tick_count = tick_count + 32'd1;
                    for (int i = 0; i < ARPC_TABLE_ENTRIES; i++) begin
                        if (slot_live[i]) begin
                            since_use   = tick_count - slot_touched[i];
                            since_learn = tick_count - slot_learned[i];
                            // A probed entry is kept and not tested for expiry.
                            if (since_use < busy_window && since_learn > probe_after) begin
                                owe_slot(STAT_PROBE, i, 1'b0);
                            end else if (since_learn > age_limit) begin
                                slot_live[i] = 1'b0;
                                owe_slot(STAT_EXPIRED, i, 1'b0);
                            end
                        end
                    end
                    owe(STAT_TICK_DONE, '0, '0, '0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, what);
        endfunction

        function void check_reply(arpc_out_t got);
            arpc_out_t want;
            if (replies_due.size() == 0) begin
                report($sformatf("unexpected beat: status %0d ip %h mac %h iface %0d last %0b",
                                 got.status, got.ip_out, got.mac_out, got.iface_out, got.last));
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status || got.ip_out !== want.ip_out ||
                got.mac_out !== want.mac_out || got.iface_out !== want.iface_out ||
                got.last !== want.last)
                report($sformatf({"beat mismatch: expected status %0d ip %h mac %h iface %0d ",
                                  "last %0b, got status %0d ip %h mac %h iface %0d last %0b"},
                                 want.status, want.ip_out, want.mac_out, want.iface_out,
                                 want.last, got.status, got.ip_out, got.mac_out,
                                 got.iface_out, got.last));
        endfunction
    endclass

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    wire logic          s_ready;
    arpc_in_t           s_data = '0;
    wire logic          m_valid;
    logic               m_ready = 1'b0;
    arpc_out_t          m_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    wire [PDATA_W-1:0]  prdata;
    wire logic          pready;

    arp_cache_shadow board;
    logic [31:0]     ip_pool[24];
    bit              gaps_on = 1'b0;
    bit              stall_on = 1'b0;
    int              stall_left = 0;

    arp_cache_table_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("arp_cache_table_unit regression: fail");
        $finish;
    end

    // Receiver stalls come in random bursts while stall_on is set.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_reply(m_data);
    end

    function automatic arpc_in_t make_request(logic [1:0] kind, logic [31:0] ip,
                                              logic [47:0] mac, logic [1:0] iface);
        arpc_in_t rq;
        rq.req_type  = kind;
        rq.ip_key    = ip;
        rq.mac_value = mac;
        rq.iface_id  = iface;
        return rq;
    endfunction

    function automatic arpc_in_t random_request();
        int          roll;
        logic [1:0]  kind;
        logic [31:0] ip;
        roll = $urandom_range(0, 99);
        if (roll < 36)
            kind = REQ_LEARN;
        else if (roll < 68)
            kind = REQ_LOOKUP;
        else if (roll < 96)
            kind = REQ_TICK;
        else
            kind = REQ_NONE;
        // Mostly reuse a small address set so refreshes and hits happen often.
        if ($urandom_range(0, 99) < 85)
            ip = ip_pool[$urandom_range(0, 23)];
        else
            ip = $urandom();
        return make_request(kind, ip, {16'($urandom()), 32'($urandom())},
                            2'($urandom_range(0, 3)));
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] word;
        logic [31:0] junk;
        junk = $urandom();
        word = value;
        // Bits above the register width carry noise; the block must drop them.
        if (idx == CFG_PROBE_WINDOW)
            word[31:8] = junk[31:8];
        else
            word[31:16] = junk[31:16];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        board.set_register(idx, word);
    endtask

    task automatic send_request(input arpc_in_t rq);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rq;
        do @(posedge aclk); while (!s_ready);
        board.absorb_request(rq);
    endtask

    // Wait until every owed beat is back, then give the block time to finish
    // an ignored request before anything else happens.
    task automatic drain_replies();
        s_valid <= 1'b0;
        while (board.replies_due.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [15:0] expire, input logic [7:0] window,
                             input logic [15:0] probe, input int count, input bit idling);
        arpc_in_t rq;
        int       sent;
        drain_replies();
        apb_write(CFG_EXPIRE_AGE, {16'd0, expire});
        apb_write(CFG_PROBE_WINDOW, {24'd0, window});
        apb_write(CFG_PROBE_AGE, {16'd0, probe});
        gaps_on  = idling;
        stall_on = idling;
        sent = 0;
        while (sent < count) begin
            rq = random_request();
            send_request(rq);
            if (rq.req_type != REQ_NONE)
                sent++;
        end
    endtask

    initial begin
        board = new();
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 24; i++)
            ip_pool[i] = $urandom();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        gaps_on  = 1'b1;
        stall_on = 1'b1;

        // Extremes, refresh keeping the stored MAC, hit, miss, an ignored request and a tick.
        send_request(make_request(REQ_LEARN, 32'h0, 48'h0, 2'd0));
        send_request(make_request(REQ_LEARN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 2'd3));
        send_request(make_request(REQ_LEARN, 32'h0, 48'h1234_5678_9ABC, 2'd2));
        send_request(make_request(REQ_LOOKUP, 32'hFFFF_FFFF, 48'h0, 2'd0));
        send_request(make_request(REQ_LOOKUP, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF, 2'd3));
        send_request(make_request(REQ_NONE, $urandom(), 48'hA5A5_5A5A_A5A5, 2'd1));
        send_request(make_request(REQ_TICK, 32'h0, 48'h0, 2'd0));
        // Fill the table, then one more learn finds it full.
        for (int i = 2; i < 17; i++)
            send_request(make_request(REQ_LEARN, ip_pool[i],
                                      {16'($urandom()), 32'($urandom())},
                                      2'($urandom_range(0, 3))));
        drain_replies();
        // Everything counts as in use and old enough, so every entry is probed.
        apb_write(CFG_PROBE_WINDOW, 32'd255);
        apb_write(CFG_PROBE_AGE, 32'd0);
        send_request(make_request(REQ_TICK, 32'h0, 48'h0, 2'd0));
        drain_replies();
        // Nothing is in use now and the age limit is minimal, so all entries expire.
        apb_write(CFG_EXPIRE_AGE, 32'd1);
        apb_write(CFG_PROBE_WINDOW, 32'd0);
        apb_write(CFG_PROBE_AGE, 32'd65535);
        apb_write(CFG_UNMAPPED, $urandom());
        send_request(make_request(REQ_TICK, 32'h0, 48'h0, 2'd0));
        send_request(make_request(REQ_TICK, 32'h0, 48'h0, 2'd0));

        run_phase(16'd65535, 8'd255, 16'd65535, 50, 1'b1);
        run_phase(16'd1, 8'd0, 16'd0, 50, 1'b1);
        run_phase(16'd12, 8'd4, 16'd3, 50, 1'b1);
        run_phase(16'd6, 8'd255, 16'd0, 50, 1'b0);
        run_phase(16'd25, 8'd8, 16'd10, 50, 1'b1);
        run_phase(16'($urandom_range(2, 40)), 8'($urandom_range(0, 16)),
                  16'($urandom_range(0, 30)), 50, 1'b1);
        run_phase(16'd9, 8'd3, 16'd2, 50, 1'b0);
        drain_replies();

        if (board.mismatches == 0 && board.replies_due.size() == 0)
            $display("arp_cache_table_unit regression: pass");
        else
            $display("arp_cache_table_unit regression: fail");
        $finish;
    end
endmodule

// File: arp_cache_table_unit.f
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arpc_cfg.sv
rtl/arp_cache_table_unit.sv
test/testbench.sv
